/* sv/jsu_pkg.sv */
// shared types and constants of the json string unescape block
package jsu_pkg;

    // default depth of the job queue between front and back
    // room for a surrogate pair job plus the items that follow it at full rate
    localparam int unsigned QUEUE_DEPTH = 8;

    // widths of the stream payloads
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;

    // bytes of interest
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // surrogate bounds
    localparam logic [15:0] HI_SURR_MIN = 16'hd800;
    localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
    localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
    localparam logic [15:0] LO_SURR_MAX = 16'hdfff;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // one queue entry: the results caused by one accepted item
    typedef struct packed {
        logic [3:0][7:0] bytes;    // decoded bytes, first in entry 0
        logic [1:0]      last_idx; // index of the last valid byte
        logic            is_end;   // end-of-token entry, carries status
        logic            status;   // 1 = malformed token
    } t_job;

endpackage

/* sv/jsu_front.sv */
// front part: accepts content items, tracks escapes and builds result jobs
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    output logic          o_ready,
    output logic          o_push,
    output jsu_pkg::t_job o_job,
    input  logic          i_full
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } t_phase;

    // hex digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // utf-8 encoding of a code point into a job
    function automatic t_job encode(input logic [20:0] cp);
        t_job j;
        j = '0;
        if (cp <= 21'h7f) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp <= 21'h7ff) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp <= 21'hffff) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    logic        r_err, n_err;

    logic        accept;
    logic [4:0]  digit;
    logic [15:0] hex_next;
    logic [20:0] cp_pair;
    logic [20:0] cp_sel;
    t_job        enc_job;
    t_job        job;
    logic        push;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign digit    = hex_value(i_byte);
    assign hex_next = {r_hex[11:0], digit[3:0]};
    assign cp_pair  = SUPP_BASE + {1'b0, r_hs, hex_next[9:0]};
    assign cp_sel   = (r_phase == PH_HEX2) ? cp_pair : {5'b0, hex_next};
    assign enc_job  = encode(cp_sel);

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        n_err   = r_err;
        push    = 1'b0;
        job     = '0;
        if (accept) begin
            if (i_end) begin
                push       = 1'b1;
                job.is_end = 1'b1;
                job.status = r_err || (r_phase != PH_NORMAL);
                n_phase    = PH_NORMAL;
                n_hex      = '0;
                n_cnt      = '0;
                n_hs       = '0;
                n_err      = 1'b0;
            end else if (!r_err) begin
                case (r_phase)
                    PH_NORMAL: begin
                        if (i_byte == CH_BACKSLASH) begin
                            n_phase = PH_ESC;
                        end else if (i_byte < CH_SPACE) begin
                            n_err = 1'b1;
                        end else begin
                            push         = 1'b1;
                            job.bytes[0] = i_byte;
                        end
                    end
                    PH_ESC: begin
                        n_phase = PH_NORMAL;
                        push    = 1'b1;
                        case (i_byte)
                            CH_QUOTE:     job.bytes[0] = CH_QUOTE;
                            CH_BACKSLASH: job.bytes[0] = CH_BACKSLASH;
                            CH_SLASH:     job.bytes[0] = CH_SLASH;
                            CH_B:         job.bytes[0] = 8'h08;
                            CH_F:         job.bytes[0] = 8'h0c;
                            CH_N:         job.bytes[0] = 8'h0a;
                            CH_R:         job.bytes[0] = 8'h0d;
                            CH_T:         job.bytes[0] = 8'h09;
                            CH_U: begin
                                push    = 1'b0;
                                n_phase = PH_HEX1;
                                n_hex   = '0;
                                n_cnt   = '0;
                            end
                            default: begin
                                push  = 1'b0;
                                n_err = 1'b1;
                            end
                        endcase
                    end
                    PH_HEX1, PH_HEX2: begin
                        if (digit[4]) begin
                            n_err = 1'b1;
                        end else if (r_cnt != 2'd3) begin
                            n_hex = hex_next;
                            n_cnt = r_cnt + 2'd1;
                        end else begin
                            n_cnt = '0;
                            n_hex = '0;
                            if (r_phase == PH_HEX1) begin
                                if (hex_next >= HI_SURR_MIN && hex_next <= HI_SURR_MAX) begin
                                    n_hs    = hex_next[9:0];
                                    n_phase = PH_WANT_BS;
                                end else if (hex_next >= LO_SURR_MIN &&
                                             hex_next <= LO_SURR_MAX) begin
                                    n_err = 1'b1;
                                end else begin
                                    push    = 1'b1;
                                    job     = enc_job;
                                    n_phase = PH_NORMAL;
                                end
                            end else begin
                                if (hex_next < LO_SURR_MIN || hex_next > LO_SURR_MAX) begin
                                    n_err = 1'b1;
                                end else begin
                                    push    = 1'b1;
                                    job     = enc_job;
                                    n_phase = PH_NORMAL;
                                end
                            end
                        end
                    end
                    PH_WANT_BS: begin
                        if (i_byte == CH_BACKSLASH) begin
                            n_phase = PH_WANT_U;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_WANT_U: begin
                        if (i_byte == CH_U) begin
                            n_phase = PH_HEX2;
                            n_hex   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_NORMAL;
                        n_err   = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_push = push;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_hex   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
            r_err   <= n_err;
        end
    end

endmodule

/* sv/jsu_fifo.sv */
// job queue between front and back
module jsu_fifo #(
    parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output jsu_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import jsu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/jsu_back.sv */
// back part: unpacks queued jobs, one item per unstalled cycle
module jsu_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  jsu_pkg::t_job                  i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [jsu_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                           o_tuser,
    output logic                           o_tlast
);
    import jsu_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_user;
    logic                  r_last;
    logic [1:0]            r_idx;
    logic                  load;
    logic                  take;
    logic                  job_done;

    assign load     = !r_valid || i_tready;
    assign take     = load && !i_empty;
    assign job_done = i_head.is_end || (r_idx == i_head.last_idx);
    assign o_pop    = take && job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_idx   <= job_done ? 2'd0 : r_idx + 2'd1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_head.is_end) begin
                r_data <= {{(OUT_DATA_W-9){1'b0}}, i_head.status, 8'h00};
                r_user <= 1'b0;
                r_last <= 1'b1;
            end else begin
                r_data <= {{(OUT_DATA_W-8){1'b0}}, i_head.bytes[r_idx]};
                r_user <= 1'b1;
                r_last <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

endmodule

/* sv/json_string_unescape_utf8.sv */
// top level: json string unescape with utf-8 output, front/queue/back
// results are registered in the job queue, then the output register; throughput: one
//   input item per cycle while the queue has room, one result out per ready cycle, so
//   a \u escape (6 or 12 items in, up to 4 bytes out) never backs up the input
// reset: synchronous, active low; clears escape state, queue and output valid flag
module json_string_unescape_utf8 #(
    parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [jsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] content_byte
    input  logic                           s_axis_tlast,  // token_end
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [jsu_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [8] status
    output logic                           m_axis_tuser,  // byte_valid
    output logic                           m_axis_tlast   // last
);
    import jsu_pkg::*;

    // front to queue
    logic push;
    t_job push_job;
    logic full;

    // queue to back
    t_job head;
    logic empty;
    logic pop;

    // escape decoding and utf-8 encoding, one item per cycle while the queue is not full
    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata[7:0]),
        .i_end   (s_axis_tlast),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // short queue of jobs so front and back stall independently
    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    // unpacks each job into byte items or the final status item
    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

/* sv/jsu_checker.sv */
// port-level checks of the json string unescape block, bound to the top level
module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // the final item of a token carries no byte
    a_last_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && (m_axis_tdata[7:0] == 8'h00))
        else $error("final item carries a byte");

    // a byte item has clear status and every non-final item is a byte
    a_byte_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && !m_axis_tdata[8])
        else $error("byte item with status or without byte flag");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'h00))
        else $error("nonzero padding in output item");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
